FILE: design/swfr_pkg.sv
// shared constants and types for the sync word frame receiver
package swfr_pkg;

  localparam int unsigned FRAME_BYTES = 22;
  localparam int unsigned CNT_W       = $clog2(FRAME_BYTES);

  // reset value of the start word: first byte on the line is the low half
  localparam logic [7:0]  SYNC_HI    = 8'hAB;
  localparam logic [7:0]  SYNC_LO    = 8'hCD;
  localparam logic [15:0] SYNC_RESET = {SYNC_HI, SYNC_LO};

  // byte positions inside a frame
  localparam logic [CNT_W-1:0] POS_FIRST_DATA = CNT_W'(2);
  localparam logic [CNT_W-1:0] POS_CHK_LO     = CNT_W'(FRAME_BYTES - 2);
  localparam logic [CNT_W-1:0] POS_LAST       = CNT_W'(FRAME_BYTES - 1);

  typedef logic [CNT_W-1:0] count_t;

  typedef struct packed {
    logic        frame_ok;
    logic [15:0] command_one;
    logic [15:0] command_two;
    logic [15:0] speed_right;
    logic [15:0] speed_left;
    logic [15:0] count_right;
    logic [15:0] count_left;
    logic [15:0] battery_raw;
    logic [15:0] temperature_raw;
    logic [15:0] led_word;
  } result_t;

endpackage

FILE: design/swfr_frame_core.sv
// frame tracking: sync detect, byte store, running xor and result build
module swfr_frame_core import swfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_vld,
  input  logic [7:0]  rx_byte,
  input  logic [15:0] sync_word,
  output logic        res_vld,
  output result_t     res
);

  logic [7:0]  last_byte_r, last_byte_nxt;
  count_t      count_r, count_nxt;
  logic [15:0] xor_r, xor_nxt;
  logic [7:0]  store_r [FRAME_BYTES];

  logic [15:0] pair;
  logic        hit;
  logic        in_frame;
  logic        done;

  assign pair     = {rx_byte, last_byte_r};
  assign hit      = (pair == sync_word);
  assign in_frame = (count_r >= POS_FIRST_DATA) && (count_r <= POS_LAST);
  assign done     = byte_vld && !hit && (count_r == POS_LAST);

  always_comb begin
    last_byte_nxt = byte_vld ? rx_byte : last_byte_r;
    count_nxt     = count_r;
    xor_nxt       = xor_r;
    if (byte_vld) begin
      if (hit) begin
        count_nxt = POS_FIRST_DATA;
        xor_nxt   = pair;
      end else if (done) begin
        count_nxt = '0;
      end else if (in_frame) begin
        count_nxt = count_r + count_t'(1);
        if (count_r < POS_CHK_LO) begin
          // even positions land in the low half of a word
          xor_nxt = xor_r ^ (count_r[0] ? {rx_byte, 8'h00} : {8'h00, rx_byte});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_byte_r <= '0;
      count_r     <= '0;
      xor_r       <= '0;
    end else begin
      last_byte_r <= last_byte_nxt;
      count_r     <= count_nxt;
      xor_r       <= xor_nxt;
    end
  end

  // frame bytes, no reset: only read at a frame's last byte, once the earlier ones are written
  always_ff @(posedge clk) begin
    if (byte_vld) begin
      if (hit) begin
        store_r[0] <= last_byte_r;
        store_r[1] <= rx_byte;
      end else if (in_frame) begin
        store_r[count_r] <= rx_byte;
      end
    end
  end

  assign res_vld = done;

  always_comb begin
    res.frame_ok        = ({store_r[1], store_r[0]} == sync_word) &&
                          ({rx_byte, store_r[POS_CHK_LO]} == xor_r);
    res.command_one     = {store_r[3],  store_r[2]};
    res.command_two     = {store_r[5],  store_r[4]};
    res.speed_right     = {store_r[7],  store_r[6]};
    res.speed_left      = {store_r[9],  store_r[8]};
    res.count_right     = {store_r[11], store_r[10]};
    res.count_left      = {store_r[13], store_r[12]};
    res.battery_raw     = {store_r[15], store_r[14]};
    res.temperature_raw = {store_r[17], store_r[16]};
    res.led_word        = {store_r[19], store_r[18]};
  end

`ifndef SYNTH
  a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != count_t'(1) && count_r <= POS_LAST)
    else $error("byte count left its legal set");

  a_sync_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    byte_vld && hit |=> count_r == POS_FIRST_DATA)
    else $error("sync pair did not restart the frame");

  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |=> count_r == '0)
    else $error("count not cleared after a full frame");

  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    byte_vld |=> last_byte_r == $past(rx_byte))
    else $error("previous byte not tracked");
`endif

endmodule

FILE: design/swfr_out_reg.sv
// result register holding one frame until the consumer takes it
module swfr_out_reg import swfr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res_in,
  input  logic    out_stall,
  output logic    out_valid,
  output logic    out_free,
  output result_t res_out
);

  logic    valid_r, valid_nxt;
  result_t data_r;

  assign out_free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load)            valid_nxt = 1'b1;
    else if (!out_stall) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = data_r;

endmodule

FILE: design/sync_word_frame_receiver_xor_check.sv
// top level of the sync word frame receiver with xor checksum
// Takes one serial byte per beat and looks for the two-byte start word
// (first byte low half, held in the cfg register, reset 0xABCD). A start
// word seen anywhere, even inside a frame, restarts the frame. After the
// 22nd byte (eleven little-endian words: start, two commands, speeds,
// counts, voltage, temperature, led, checksum) one result beat carries the
// raw words and frame_ok, which is set when the start word still matches the
// register and the xor of the first ten words equals the checksum word.
// Bytes that finish no frame give no result. A frame's last byte passes the
// input register, then the result register. A byte is taken every cycle
// while the result side is not stalling; a result left waiting holds the
// byte stage, and through it the input. Unenforced by the block, the user
// must write the sync register through cfg only while the block is idle.
module sync_word_frame_receiver_xor_check import swfr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // byte input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  // sync word register
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_sync_word,
  // frame results
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_frame_ok,
  output logic signed [15:0] out_command_one,
  output logic signed [15:0] out_command_two,
  output logic signed [15:0] out_speed_right,
  output logic signed [15:0] out_speed_left,
  output logic signed [15:0] out_count_right,
  output logic signed [15:0] out_count_left,
  output logic signed [15:0] out_battery_raw,
  output logic signed [15:0] out_temperature_raw,
  output logic [15:0]        out_led_word
);

  // input register stage
  logic        byte_vld_r, byte_vld_nxt;
  logic [7:0]  byte_r;
  logic [15:0] sync_word_r;

  // handoff between stages
  logic        adv;
  logic        out_free;
  logic        res_vld;
  result_t     res;
  result_t     res_q;

  // the byte stage moves on once the result register can take a beat
  assign adv      = byte_vld_r && out_free;
  assign in_stall = byte_vld_r && !out_free;
  assign cfg_ready = 1'b1;

  always_comb begin
    byte_vld_nxt = byte_vld_r;
    if (!byte_vld_r || adv) byte_vld_nxt = in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r  <= 1'b0;
      sync_word_r <= SYNC_RESET;
    end else begin
      byte_vld_r <= byte_vld_nxt;
      if (cfg_valid && cfg_ready) sync_word_r <= cfg_sync_word;
    end
  end

  // byte payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_rx_byte;
    end
  end

  swfr_frame_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_vld  (adv),
    .rx_byte   (byte_r),
    .sync_word (sync_word_r),
    .res_vld   (res_vld),
    .res       (res)
  );

  swfr_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_vld),
    .res_in    (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_free  (out_free),
    .res_out   (res_q)
  );

  assign out_frame_ok        = res_q.frame_ok;
  assign out_command_one     = res_q.command_one;
  assign out_command_two     = res_q.command_two;
  assign out_speed_right     = res_q.speed_right;
  assign out_speed_left      = res_q.speed_left;
  assign out_count_right     = res_q.count_right;
  assign out_count_left      = res_q.count_left;
  assign out_battery_raw     = res_q.battery_raw;
  assign out_temperature_raw = res_q.temperature_raw;
  assign out_led_word        = res_q.led_word;

endmodule
